### rtl/tsd_pkg.sv
// shared constants for the two-body thrust state derivative pipeline
package tsd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int CFG_W         = 31;
    localparam int ROOT_W        = 32;
    localparam int SQ_W          = 64;
    localparam int CUBE_W        = 96;
    localparam int GNUM_W        = WORD_W + CFG_W;

    // quotient bits resolved by the divider, and the capped magnitude width
    localparam int QUO_BITS = 35;
    localparam int MAG_W    = 34;
    localparam logic [MAG_W-1:0] TERM_CAP = MAG_W'(64'h2_0000_0000);

    // register stages inside one divider
    localparam int DIV_LAT = QUO_BITS + 1;

    // configuration register indexes
    localparam logic [0:0] CFG_IDX_GRAV = 1'b0;
    localparam logic [0:0] CFG_IDX_MASS = 1'b1;

endpackage

### rtl/tsd_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, result zeroed on request or capped
module tsd_div_pipe #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [NW-1:0]             num,
    input  logic [DW-1:0]             den,
    input  logic                      zero,
    output logic [tsd_pkg::MAG_W-1:0] q
);
    import tsd_pkg::*;

    localparam int W = (NW > DW + QUO_BITS) ? NW : DW + QUO_BITS;

    logic [W-1:0]        rem_reg  [0:QUO_BITS-1];
    logic [QUO_BITS-1:0] quo_reg  [0:QUO_BITS-1];
    logic [DW-1:0]       den_reg  [0:QUO_BITS-1];
    logic                zero_reg [0:QUO_BITS-1];
    logic                ovf_reg  [0:QUO_BITS-1];
    logic [W-1:0]        rem_next [1:QUO_BITS];
    logic [QUO_BITS-1:0] quo_next [1:QUO_BITS];
    logic [MAG_W-1:0]    q_reg;
    logic                ovf_next;

    // quotient would not fit in the resolved bits
    assign ovf_next = W'(num) >= (W'(den) << QUO_BITS);

    // entry stage
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= W'(num);
            quo_reg[0]  <= '0;
            den_reg[0]  <= den;
            zero_reg[0] <= zero;
            ovf_reg[0]  <= ovf_next;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar s = 1; s <= QUO_BITS; s++) begin : g_bit
        localparam int B = QUO_BITS - s;
        logic [W-1:0] trial;

        assign trial = W'(den_reg[s-1]) << B;

        always_comb begin
            if (rem_reg[s-1] >= trial) begin
                rem_next[s] = rem_reg[s-1] - trial;
                quo_next[s] = quo_reg[s-1] | (QUO_BITS'(1) << B);
            end else begin
                rem_next[s] = rem_reg[s-1];
                quo_next[s] = quo_reg[s-1];
            end
        end

        if (s < QUO_BITS) begin : g_reg
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s]  <= rem_next[s];
                    quo_reg[s]  <= quo_next[s];
                    den_reg[s]  <= den_reg[s-1];
                    zero_reg[s] <= zero_reg[s-1];
                    ovf_reg[s]  <= ovf_reg[s-1];
                end
            end
        end
    end

    // force zero, then cap
    always_ff @(posedge aclk) begin
        if (en) begin
            if (zero_reg[QUO_BITS-1]) begin
                q_reg <= '0;
            end else if (ovf_reg[QUO_BITS-1] ||
                         quo_next[QUO_BITS] > QUO_BITS'(TERM_CAP)) begin
                q_reg <= TERM_CAP;
            end else begin
                q_reg <= quo_next[QUO_BITS][MAG_W-1:0];
            end
        end
    end

    assign q = q_reg;

endmodule

### rtl/twobody_thrust_state_derivative_top.sv
// top level: two-body gravity plus thrust state derivative pipeline
//
// Takes one state beat (position, velocity, thrust, signed fixed point with
// FRAC_BITS fraction bits) per cycle and returns one derivative beat per
// cycle unless frozen. From an accepted input beat to its output beat, a
// 32-stage square root of the squared radius, three stages forming r^3, and
// a 36-stage bit-per-stage divider for each gravity and thrust term dominate
// the path. The whole pipeline advances together and freezes while an output
// beat is waiting and m_tready is low. The user must write gravity and mass
// through the cfg port only while no beat is in flight; the block never checks.
module twobody_thrust_state_derivative_top #(
    parameter int FRAC_BITS = tsd_pkg::FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // cfg write port
    input  logic                     cfg_wr_en,
    input  logic [0:0]               cfg_index,
    input  logic [tsd_pkg::CFG_W-1:0] cfg_data,
    // input beat
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, thrust_x, thrust_y, thrust_z
    input  logic [287:0]             s_tdata,
    // result beat
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // rate_pos_x, rate_pos_y, rate_pos_z, accel_x, accel_y, accel_z
    output logic [191:0]             m_tdata,
    // singular
    output logic [0:0]               m_tuser
);
    import tsd_pkg::*;

    localparam int GN_W     = GNUM_W + 2 * FRAC_BITS;
    localparam int TN_W     = WORD_W + FRAC_BITS;
    localparam int SIDE_LEN = 37 + DIV_LAT;
    localparam int PIPE_LEN = 39 + DIV_LAT;
    localparam int FEED     = 36;

    typedef struct packed {
        logic [2:0][WORD_W-1:0] vel;
        logic [2:0]             pn;
        logic [2:0]             tn;
        logic [2:0][WORD_W-1:0] tm;
        logic [2:0][GNUM_W-1:0] gnum;
    } side_t;

    logic [CFG_W-1:0]  grav_reg;
    logic [CFG_W-1:0]  mass_reg;
    logic              en;
    logic [PIPE_LEN-1:0] vld_reg;

    logic [2:0][WORD_W-1:0] pm1_reg;
    logic [2:0]             pn1_reg;
    logic [2:0][WORD_W-1:0] tm1_reg;
    logic [2:0]             tn1_reg;
    logic [2:0][WORD_W-1:0] vel1_reg;
    logic [2:0][SQ_W-1:0]   sq2_reg;
    logic [SQ_W-1:0]        r2_reg;
    side_t                  side_reg [0:SIDE_LEN-1];

    logic [SQ_W-1:0]   sr_rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] sr_root_reg [0:ROOT_W-1];

    logic [SQ_W-1:0]   rr_reg;
    logic [ROOT_W-1:0] r36_reg;
    logic [SQ_W-1:0]   p0_reg;
    logic [SQ_W-1:0]   p1_reg;
    logic              sing37_reg;
    logic [CUBE_W-1:0] r3_reg;
    logic              sing38_reg;
    logic              sing_d_reg [0:DIV_LAT-1];

    logic [2:0][MAG_W-1:0]  gmag;
    logic [2:0][MAG_W-1:0]  tmag;
    logic [2:0][WORD_W-1:0] acc_sat;
    logic [191:0]           out_data_reg;
    logic                   out_sing_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg <= CFG_W'(65536);
            mass_reg <= CFG_W'(65536);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDX_GRAV: grav_reg <= cfg_data;
                CFG_IDX_MASS: mass_reg <= cfg_data;
                default:      grav_reg <= grav_reg;
            endcase
        end
    end

    // whole pipe moves unless the output beat is held
    assign en       = !vld_reg[PIPE_LEN-1] || m_tready;
    assign s_tready = en && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], s_tvalid};
        end
    end

    // stage 1: magnitudes and signs
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pn1_reg[k]  <= s_tdata[32*k+31];
                pm1_reg[k]  <= s_tdata[32*k+31] ? (~s_tdata[32*k +: 32]) + 32'd1
                                                : s_tdata[32*k +: 32];
                tn1_reg[k]  <= s_tdata[192+32*k+31];
                tm1_reg[k]  <= s_tdata[192+32*k+31] ? (~s_tdata[192+32*k +: 32]) + 32'd1
                                                    : s_tdata[192+32*k +: 32];
                vel1_reg[k] <= s_tdata[96+32*k +: 32];
            end
        end
    end

    // stage 2: squares and gravity numerators, plus the side data delay line
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                sq2_reg[k]          <= SQ_W'(pm1_reg[k]) * SQ_W'(pm1_reg[k]);
                side_reg[0].gnum[k] <= GNUM_W'(grav_reg) * GNUM_W'(pm1_reg[k]);
            end
            side_reg[0].vel <= vel1_reg;
            side_reg[0].pn  <= pn1_reg;
            side_reg[0].tn  <= tn1_reg;
            side_reg[0].tm  <= tm1_reg;
            for (int n = 1; n < SIDE_LEN; n++) begin
                side_reg[n] <= side_reg[n-1];
            end
        end
    end

    // stage 3: squared radius
    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
        end
    end

    // square root, one root bit per stage, msb first
    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int I = ROOT_W - 1 - j;
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W+1:0]   delta;

        assign rem_in  = (j == 0) ? r2_reg : sr_rem_reg[(j == 0) ? 0 : j-1];
        assign root_in = (j == 0) ? '0     : sr_root_reg[(j == 0) ? 0 : j-1];
        assign delta   = ((SQ_W+2)'(root_in) << (I + 1)) + ((SQ_W+2)'(1) << (2 * I));

        always_ff @(posedge aclk) begin
            if (en) begin
                if ((SQ_W+2)'(rem_in) >= delta) begin
                    sr_rem_reg[j]  <= rem_in - delta[SQ_W-1:0];
                    sr_root_reg[j] <= root_in | (ROOT_W'(1) << I);
                end else begin
                    sr_rem_reg[j]  <= rem_in;
                    sr_root_reg[j] <= root_in;
                end
            end
        end
    end

    // cube of the radius over three stages
    always_ff @(posedge aclk) begin
        if (en) begin
            rr_reg     <= SQ_W'(sr_root_reg[ROOT_W-1]) * SQ_W'(sr_root_reg[ROOT_W-1]);
            r36_reg    <= sr_root_reg[ROOT_W-1];
            p0_reg     <= SQ_W'(rr_reg[31:0]) * SQ_W'(r36_reg);
            p1_reg     <= SQ_W'(rr_reg[63:32]) * SQ_W'(r36_reg);
            sing37_reg <= (r36_reg == '0);
            r3_reg     <= CUBE_W'(p0_reg) + (CUBE_W'(p1_reg) << 32);
            sing38_reg <= sing37_reg;
        end
    end

    // singular flag rides beside the dividers
    always_ff @(posedge aclk) begin
        if (en) begin
            sing_d_reg[0] <= sing38_reg;
            for (int n = 1; n < DIV_LAT; n++) begin
                sing_d_reg[n] <= sing_d_reg[n-1];
            end
        end
    end

    // gravity and thrust dividers per axis
    for (genvar k = 0; k < 3; k++) begin : g_axis
        tsd_div_pipe #(
            .NW (GN_W),
            .DW (CUBE_W)
        ) u_grav_div (
            .aclk (aclk),
            .en   (en),
            .num  (GN_W'(side_reg[FEED].gnum[k]) << (2 * FRAC_BITS)),
            .den  (r3_reg),
            .zero (sing38_reg),
            .q    (gmag[k])
        );

        tsd_div_pipe #(
            .NW (TN_W),
            .DW (CFG_W)
        ) u_thr_div (
            .aclk (aclk),
            .en   (en),
            .num  (TN_W'(side_reg[FEED].tm[k]) << FRAC_BITS),
            .den  (mass_reg),
            .zero (side_reg[FEED].tm[k] == '0),
            .q    (tmag[k])
        );

        logic signed [MAG_W+1:0] gterm;
        logic signed [MAG_W+1:0] tterm;
        logic signed [MAG_W+1:0] acc;

        // gravity pulls against the coordinate sign
        assign gterm = side_reg[SIDE_LEN-1].pn[k] ? $signed({2'b00, gmag[k]})
                                                 : -$signed({2'b00, gmag[k]});
        assign tterm = side_reg[SIDE_LEN-1].tn[k] ? -$signed({2'b00, tmag[k]})
                                                 : $signed({2'b00, tmag[k]});
        assign acc   = gterm + tterm;

        // saturate to the word range
        always_comb begin
            if (acc > $signed((MAG_W+2)'(32'h7FFF_FFFF))) begin
                acc_sat[k] = 32'h7FFF_FFFF;
            end else if (acc < -$signed((MAG_W+2)'(33'h0_8000_0000))) begin
                acc_sat[k] = 32'h8000_0000;
            end else begin
                acc_sat[k] = acc[WORD_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                out_data_reg[32*k +: 32]    <= side_reg[SIDE_LEN-1].vel[k];
                out_data_reg[96+32*k +: 32] <= acc_sat[k];
            end
            out_sing_reg <= sing_d_reg[DIV_LAT-1];
        end
    end

    assign m_tvalid   = vld_reg[PIPE_LEN-1];
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sing_reg;

endmodule

### sim/testbench.sv
// testbench for the two-body thrust state derivative pipeline
`timescale 1ns / 1ps

module testbench;
    import tsd_pkg::*;

    localparam int FRAC = 16;
    localparam int PIPE_LAT = 75;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] tz, ty, tx, vz, vy, vx, pz, py, px;
    } state_t;

    typedef struct {
        logic [31:0] rate [3];
        logic [31:0] accel [3];
        logic        singular;
    } deriv_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [0:0] cfg_index = CFG_IDX_GRAV;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [287:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [191:0] m_tdata;
    logic [0:0] m_tuser;

    // model copy of the registers
    logic [30:0] grav_reg = 31'd65536;
    logic [30:0] mass_reg = 31'd65536;

    deriv_t expected_q [$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_singular = 0;
    longint cycles = 0;
    int hold_off = 0;
    bit sink_random = 1'b1;

    twobody_thrust_state_derivative_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] magnitude(logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // derivative of one state with current gravity and mass
    function automatic deriv_t derivative(state_t st);
        deriv_t d;
        logic [31:0] pos [3], vel [3], thr [3];
        logic [63:0] pm [3];
        logic [63:0] r2, r, tm, tmag;
        logic [127:0] r3, num, gq;
        logic signed [65:0] acc;
        pos = '{st.px, st.py, st.pz};
        vel = '{st.vx, st.vy, st.vz};
        thr = '{st.tx, st.ty, st.tz};
        r2 = 0;
        for (int k = 0; k < 3; k++) begin
            pm[k] = magnitude(pos[k]);
            r2 += pm[k] * pm[k];
        end
        d.singular = (r2 == 0);
        r = isqrt(r2);
        r3 = 128'(r) * 128'(r) * 128'(r);
        for (int k = 0; k < 3; k++) begin
            gq = 0;
            if (!d.singular) begin
                num = (128'(grav_reg) * 128'(pm[k])) << (2 * FRAC);
                gq = num / r3;
                if (gq > 128'(TERM_CAP)) gq = 128'(TERM_CAP);
            end
            tm = magnitude(thr[k]);
            if (mass_reg == 0) tmag = (tm != 0) ? 64'(TERM_CAP) : 64'd0;
            else tmag = (tm << FRAC) / mass_reg;
            if (tmag > 64'(TERM_CAP)) tmag = 64'(TERM_CAP);
            acc = pos[k][31] ? $signed(66'(gq)) : -$signed(66'(gq));
            acc += thr[k][31] ? -$signed(66'(tmag)) : $signed(66'(tmag));
            if (acc > 66'sd2147483647) acc = 66'sd2147483647;
            if (acc < -66'sd2147483648) acc = -66'sd2147483648;
            d.rate[k] = vel[k];
            d.accel[k] = acc[31:0];
        end
        return d;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s at result %0d: got %h expected %h", what, n_checked, got, want);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            deriv_t w;
            if (expected_q.size() == 0) begin
                report("unexpected beat", m_tdata[31:0], 32'h0);
            end else begin
                w = expected_q.pop_front();
                for (int k = 0; k < 3; k++) begin
                    if (m_tdata[32*k +: 32] !== w.rate[k])
                        report($sformatf("rate_pos[%0d]", k), m_tdata[32*k +: 32], w.rate[k]);
                    if (m_tdata[96+32*k +: 32] !== w.accel[k])
                        report($sformatf("accel[%0d]", k), m_tdata[96+32*k +: 32], w.accel[k]);
                end
                if (m_tuser[0] !== w.singular)
                    report("singular", 32'(m_tuser[0]), 32'(w.singular));
                if (w.singular) n_singular++;
            end
            n_checked++;
        end
    end

    // receiver stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (!sink_random) begin
            m_tready <= 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2: m_tready <= 1'b0;
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // idle cycles before a beat, mostly short, now and then long
    function automatic int gap_len();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        return n;
    endfunction

    // send one state beat and record its derivative
    task automatic send_state(state_t st, bit gaps = 1'b1);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_tdata <= st;
        s_tvalid <= 1'b1;
        expected_q.push_back(derivative(st));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (PIPE_LAT + 10) @(negedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [30:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_IDX_GRAV) grav_reg = val;
        else mass_reg = val;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4);
            2: return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
            3: return {32{$urandom_range(0, 1) == 1}} ^ 32'($urandom_range(0, 255));
            default: return 32'($signed($urandom_range(0, 2 * 655360)) - 655360);
        endcase
    endfunction

    function automatic state_t rand_state();
        state_t st;
        st = {rand_word(), rand_word(), rand_word(), $urandom, $urandom, $urandom,
              rand_word(), rand_word(), rand_word()};
        if ($urandom_range(0, 29) == 0) begin
            st.px = 0; st.py = 0; st.pz = 0;
        end
        return st;
    endfunction

    task automatic test_directed();
        logic [31:0] ext [5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff};
        state_t st;
        // zero radius: gravity dropped
        send_state('0);
        send_state({32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 96'h0});
        // extremes on every field
        foreach (ext[i]) begin
            st = {9{ext[i]}};
            send_state(st);
        end
        // huge gravity near the origin
        send_state({96'h0, 96'h0, 32'h0, 32'h0, 32'h1});
        send_state({96'h0, 96'h0, 32'h0, 32'hffff_ffff, 32'h0});
        // unit circle
        send_state({32'h0, 32'h0, 32'h10000, 96'h0, 32'h0, 32'h0, 32'h10000});
        drain();
    endtask

    task automatic test_config_extremes();
        logic [30:0] gv [4] = '{31'd0, 31'd1, 31'h7fff_ffff, 31'd65536};
        logic [30:0] mv [4] = '{31'd0, 31'h7fff_ffff, 31'd1, 31'd65536};
        for (int i = 0; i < 4; i++) begin
            write_reg(CFG_IDX_GRAV, gv[i]);
            write_reg(CFG_IDX_MASS, mv[i]);
            send_state({32'h8000_0000, 32'h7fff_ffff, 32'h0, 96'h0, 32'h0, 32'h0, 32'h1});
            send_state({32'hffff_0000, 32'h0001_0000, 32'h1, 96'h0,
                        32'hfffe_0000, 32'h0002_0000, 32'h0000_8000});
            send_state(rand_state());
            drain();
        end
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_state(rand_state());
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        for (int i = 0; i < 120; i++) send_state(rand_state(), 1'b0);
        drain();
    endtask

    task automatic test_back_to_back();
        sink_random = 1'b0;
        for (int i = 0; i < 150; i++) send_state(rand_state(), 1'b0);
        drain();
        sink_random = 1'b1;
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_config_extremes();
        write_reg(CFG_IDX_GRAV, 31'd65536);
        write_reg(CFG_IDX_MASS, 31'd32768);
        test_random(300);
        test_backpressure();
        write_reg(CFG_IDX_GRAV, 31'($urandom));
        write_reg(CFG_IDX_MASS, 31'($urandom_range(1, 1 << 20)));
        test_random(250);
        test_back_to_back();
        $display("sent %0d states, checked %0d derivatives (%0d singular)",
                 n_sent, n_checked, n_singular);
        $display("covered register extremes, stalls, long hold-off and back-to-back beats");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
